[rtl/core/bfm_pkg.sv]
// Shared widths, constants and register indexes for the beacon frequency meter.
`default_nettype none

package bfm_pkg;

    localparam int unsigned FreqW   = 20;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned TickW   = 8;
    localparam int unsigned CfgIdxW = 3;

    // Dividend of the reciprocal measurement: one second in microseconds.
    localparam logic [FreqW-1:0] ScaleUs = 20'd1000000;
    // One restoring step per dividend bit.
    localparam int unsigned DivSteps = FreqW;
    localparam int unsigned DivCntW  = $clog2(DivSteps);

    localparam logic [TickW-1:0] TickMax = '1;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegHighCenter  = 3'd0;
    localparam logic [CfgIdxW-1:0] RegLowCenter   = 3'd1;
    localparam logic [CfgIdxW-1:0] RegNoiseBand   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegHighReport  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegLowReport   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegTimeoutTick = 3'd5;

    // Register values after reset.
    localparam logic [FreqW-1:0] RstHighCenter = 20'd700;
    localparam logic [FreqW-1:0] RstLowCenter  = 20'd23;
    localparam logic [FreqW-1:0] RstNoiseBand  = 20'd20;
    localparam logic [FreqW-1:0] RstHighReport = 20'd700;
    localparam logic [FreqW-1:0] RstLowReport  = 20'd23;
    localparam logic [TickW-1:0] RstTimeout    = 8'd5;

    // Operation codes of an input beat.
    localparam logic OpEdge = 1'b0;
    localparam logic OpTick = 1'b1;

endpackage

`default_nettype wire

[rtl/core/bfm_divider.sv]
// Iterative restoring divider: one quotient bit per cycle of the fixed scale by a period.
`default_nettype none

module bfm_divider
    import bfm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [TimeW-1:0] i_divisor,
    output logic                  o_done,
    output logic [FreqW-1:0]      o_quotient
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DivCntW-1:0] r_cnt, n_cnt;
    logic [TimeW-1:0]   r_div, n_div;
    logic [TimeW-1:0]   r_rem, n_rem;
    logic [FreqW-1:0]   r_dvd, n_dvd;

    logic [TimeW:0]     trial;
    logic               fits;

    // The dividend register shifts out dividend bits and shifts in quotient bits.
    assign trial = {r_rem, r_dvd[FreqW-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DivCntW'(DivSteps - 1);
            n_div  = i_divisor;
            n_rem  = '0;
            n_dvd  = ScaleUs;
        end else if (r_busy) begin
            n_rem = fits ? TimeW'(trial - {1'b0, r_div}) : trial[TimeW-1:0];
            n_dvd = {r_dvd[FreqW-2:0], fits};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_div <= n_div;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

`default_nettype wire

[rtl/core/bfm_band_check.sv]
// Band test shared by both beacon bands: is the quotient strictly inside center +/- band.
`default_nettype none

module bfm_band_check
    import bfm_pkg::*;
(
    input  wire logic [FreqW-1:0] i_quotient,
    input  wire logic [FreqW-1:0] i_center,
    input  wire logic [FreqW-1:0] i_band,
    output logic                  o_inside
);

    logic [FreqW:0] q_plus_band;
    logic [FreqW:0] c_plus_band;

    // center - band < q is rewritten as center < q + band, so no signed math is needed.
    assign q_plus_band = {1'b0, i_quotient} + {1'b0, i_band};
    assign c_plus_band = {1'b0, i_center} + {1'b0, i_band};
    assign o_inside    = (q_plus_band > {1'b0, i_center}) &&
                         ({1'b0, i_quotient} < c_plus_band);

endmodule

`default_nettype wire

[rtl/core/beacon_frequency_meter.sv]
// Top level of the beacon frequency meter: sequencer, state and channel registers.
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+--------------------------------
//  in      | sink      | i_in_valid/o_in_stall  | i_operation, i_timestamp_us
//  out     | source    | o_out_valid/i_out_stall| o_frequency_hz
//  cfg     | sink      | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A tick beat goes from acceptance through ST_OUT back to ST_IDLE before the block is ready again.
// An edge beat runs the restoring divider, one quotient bit per cycle; then ST_DIV takes
// the quotient, ST_HIGH and, unless the high band matches, ST_LOW step the single band
// checker through the high and then the low band, and ST_OUT loads the result before
// ST_IDLE accepts the next beat.
// The result sits in an output register, so the next beat is accepted while an
// earlier result still waits; the block holds off input while a beat is in
// progress, and a new result waits while the output register is full under stall.
// Reset is synchronous and active low; it restores the state, configuration and most
// measurement registers to their documented values and empties the output register.
`default_nettype none

module beacon_frequency_meter
    import bfm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_operation,
    input  wire logic [TimeW-1:0]   i_timestamp_us,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [FreqW-1:0]        o_frequency_hz,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [FreqW-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_HIGH,
        ST_LOW,
        ST_OUT
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [FreqW-1:0] r_high_center, n_high_center;
    logic [FreqW-1:0] r_low_center,  n_low_center;
    logic [FreqW-1:0] r_noise_band,  n_noise_band;
    logic [FreqW-1:0] r_high_report, n_high_report;
    logic [FreqW-1:0] r_low_report,  n_low_report;
    logic [TickW-1:0] r_timeout,     n_timeout;

    // Measurement state.
    logic [TimeW-1:0] r_last_edge, n_last_edge;
    logic [FreqW-1:0] r_freq,      n_freq;
    logic             r_pulse,     n_pulse;
    logic [TickW-1:0] r_ticks,     n_ticks;
    logic             r_zero,      n_zero;
    logic [FreqW-1:0] r_quot,      n_quot;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [FreqW-1:0] r_out_freq,  n_out_freq;

    logic             in_accept;
    logic             out_free;
    logic [TimeW-1:0] period;
    logic [TickW-1:0] ticks_inc;
    logic             div_start;
    logic             div_done;
    logic [FreqW-1:0] div_quot;
    logic [FreqW-1:0] band_center;
    logic             band_inside;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    // The subtraction wraps naturally at 32 bits, matching the free-running clock.
    assign period    = i_timestamp_us - r_last_edge;
    assign ticks_inc = (r_ticks == TickMax) ? r_ticks : r_ticks + 1'b1;
    assign div_start = (r_state == ST_IDLE) && in_accept && (i_operation == OpEdge);

    bfm_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (period),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    // One band checker serves both bands; the high band is tested first and wins.
    assign band_center = (r_state == ST_HIGH) ? r_high_center : r_low_center;

    bfm_band_check u_band (
        .i_quotient (r_quot),
        .i_center   (band_center),
        .i_band     (r_noise_band),
        .o_inside   (band_inside)
    );

    always_comb begin
        n_state       = r_state;
        n_high_center = r_high_center;
        n_low_center  = r_low_center;
        n_noise_band  = r_noise_band;
        n_high_report = r_high_report;
        n_low_report  = r_low_report;
        n_timeout     = r_timeout;
        n_last_edge   = r_last_edge;
        n_freq        = r_freq;
        n_pulse       = r_pulse;
        n_ticks       = r_ticks;
        n_zero        = r_zero;
        n_quot        = r_quot;
        n_out_valid   = r_out_valid;
        n_out_freq    = r_out_freq;

        // The downstream side takes the waiting beat.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegHighCenter:  n_high_center = i_cfg_data;
                RegLowCenter:   n_low_center  = i_cfg_data;
                RegNoiseBand:   n_noise_band  = i_cfg_data;
                RegHighReport:  n_high_report = i_cfg_data;
                RegLowReport:   n_low_report  = i_cfg_data;
                RegTimeoutTick: n_timeout     = i_cfg_data[TickW-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_operation == OpEdge) begin
                        n_pulse     = 1'b1;
                        n_ticks     = '0;
                        n_last_edge = i_timestamp_us;
                        n_zero      = (period == '0);
                        n_state     = ST_DIV;
                    end else begin
                        n_ticks = ticks_inc;
                        if (!r_pulse) begin
                            if (ticks_inc > r_timeout) begin
                                n_freq = '0;
                            end
                        end else begin
                            n_pulse = 1'b0;
                        end
                        n_state = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    // A zero period saturates to the full scale.
                    n_quot  = r_zero ? ScaleUs : div_quot;
                    n_state = ST_HIGH;
                end
            end
            ST_HIGH: begin
                if (band_inside) begin
                    n_freq  = r_high_report;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_LOW;
                end
            end
            ST_LOW: begin
                n_freq  = band_inside ? r_low_report : r_quot;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_freq  = r_freq;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_high_center <= RstHighCenter;
            r_low_center  <= RstLowCenter;
            r_noise_band  <= RstNoiseBand;
            r_high_report <= RstHighReport;
            r_low_report  <= RstLowReport;
            r_timeout     <= RstTimeout;
            r_last_edge   <= '0;
            r_freq        <= '0;
            r_pulse       <= 1'b0;
            r_ticks       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_high_center <= n_high_center;
            r_low_center  <= n_low_center;
            r_noise_band  <= n_noise_band;
            r_high_report <= n_high_report;
            r_low_report  <= n_low_report;
            r_timeout     <= n_timeout;
            r_last_edge   <= n_last_edge;
            r_freq        <= n_freq;
            r_pulse       <= n_pulse;
            r_ticks       <= n_ticks;
            r_out_valid   <= n_out_valid;
        end
        r_zero     <= n_zero;
        r_quot     <= n_quot;
        r_out_freq <= n_out_freq;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_frequency_hz = r_out_freq;

endmodule

`default_nettype wire

[rtl/core/bfm_checker.sv]
// Port-level checker for the beacon frequency meter and its bind.
`default_nettype none

module bfm_checker
    import bfm_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               i_operation,
    input wire logic [TimeW-1:0]   i_timestamp_us,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [FreqW-1:0]   o_frequency_hz
);

    // A result beat held under stall keeps its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_frequency_hz)))
        else $error("output beat changed while stalled");

    // An input beat held under stall keeps its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=>
            (i_in_valid && $stable(i_operation) && $stable(i_timestamp_us)))
        else $error("input beat changed while stalled");

    // Every accepted beat keeps the input side busy for at least the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted again right after a beat");

    // A new result only appears while an input beat is being worked on.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in progress");

    // Reset empties the output register.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind beacon_frequency_meter bfm_checker u_bfm_checker (.*);

`default_nettype wire
